// ===== rtl/hmd5_pkg.sv =====
// ----------------------------------------------------------------------------
// hmd5_pkg
// Shared types, constants and MD5 tables for the HMAC-MD5 engine.
// ----------------------------------------------------------------------------
`default_nettype none
package hmd5_pkg;

    localparam int KeyRegs = 8;
    localparam logic [7:0] IpadByte = 8'h36;
    localparam logic [7:0] OpadByte = 8'h5c;
    localparam logic [7:0] PadByte  = 8'h80;
    localparam logic [5:0] LenPos   = 6'd56;
    localparam logic [5:0] LastPos  = 6'd63;

    typedef enum logic [3:0] {
        ST_IDLE, ST_KEY, ST_MSG, ST_PAD80, ST_PADZ, ST_LEN,
        ST_POST, ST_DIG, ST_ROUND, ST_FIN, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        SRC_DATA, SRC_KEY, SRC_PAD80, SRC_ZERO, SRC_LEN, SRC_DIG
    } t_src;

    typedef struct packed {
        logic       init;
        logic       absorb;
        t_src       src;
        logic [5:0] idx;
        logic       outer;
        logic       snap;
        logic       load_work;
        logic       round;
        logic [5:0] rnd;
        logic       fin;
        logic       save_inner;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] pos;
    } t_dp_status;

    localparam logic [127:0] Md5Iv =
        {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    function automatic logic [31:0] sine_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/hmd5_dp.sv =====
// ----------------------------------------------------------------------------
// hmd5_dp
// Datapath: key registers, block buffer, byte counter and MD5 round unit.
// ----------------------------------------------------------------------------
`default_nettype none
module hmd5_dp
    import hmd5_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_item_load,
    input  wire logic [7:0]  i_data_byte,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    output logic [63:0]      o_mac_first_half,
    output logic [63:0]      o_mac_second_half
);

    logic [511:0] r_key;
    logic [7:0]   r_data;
    logic [31:0]  r_blk [16];
    logic [60:0]  r_bytes;
    logic [63:0]  r_len;
    logic [127:0] r_chain;
    logic [127:0] r_inner;
    logic [31:0]  r_a, r_b, r_c, r_d;

    logic [7:0]  n_byte;
    logic [31:0] n_f, n_sum, n_rot;
    logic [63:0] n_rot64;
    logic [3:0]  n_g, n_i4;

    always_comb begin
        case (i_cmd.src)
            SRC_DATA:  n_byte = r_data;
            SRC_KEY:   n_byte = r_key[{i_cmd.idx, 3'b000} +: 8] ^
                                (i_cmd.outer ? OpadByte : IpadByte);
            SRC_PAD80: n_byte = PadByte;
            SRC_LEN:   n_byte = r_len[{i_cmd.idx[2:0], 3'b000} +: 8];
            SRC_DIG:   n_byte = r_inner[{i_cmd.idx[3:0], 3'b000} +: 8];
            default:   n_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_i4 = i_cmd.rnd[3:0];
        case (i_cmd.rnd[5:4])
            2'd0: begin
                n_f = (r_b & r_c) | (~r_b & r_d);
                n_g = n_i4;
            end
            2'd1: begin
                n_f = (r_d & r_b) | (~r_d & r_c);
                n_g = 4'(n_i4 * 4'd5 + 4'd1);
            end
            2'd2: begin
                n_f = r_b ^ r_c ^ r_d;
                n_g = 4'(n_i4 * 4'd3 + 4'd5);
            end
            default: begin
                n_f = r_c ^ (r_b | ~r_d);
                n_g = 4'(n_i4 * 4'd7);
            end
        endcase
        n_sum   = r_a + n_f + sine_k(i_cmd.rnd) + r_blk[n_g];
        n_rot64 = {n_sum, n_sum} << rot_amt(i_cmd.rnd);
        n_rot   = n_rot64[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we && i_cfg_index < 4'(KeyRegs)) begin
            r_key[{i_cfg_index[2:0], 6'd0} +: 64] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= '0;
        end else if (i_cmd.init) begin
            r_bytes <= '0;
        end else if (i_cmd.absorb) begin
            r_bytes <= r_bytes + 61'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item_load) begin
            r_data <= i_data_byte;
        end
        if (i_cmd.snap) begin
            r_len <= {r_bytes, 3'b000};
        end
        if (i_cmd.absorb) begin
            r_blk[r_bytes[5:2]][{r_bytes[1:0], 3'b000} +: 8] <= n_byte;
        end
        if (i_cmd.save_inner) begin
            r_inner <= r_chain;
        end
        if (i_cmd.init) begin
            r_chain <= Md5Iv;
        end else if (i_cmd.fin) begin
            r_chain <= {r_chain[127:96] + r_d, r_chain[95:64] + r_c,
                        r_chain[63:32] + r_b, r_chain[31:0] + r_a};
        end
        if (i_cmd.load_work) begin
            r_a <= r_chain[31:0];
            r_b <= r_chain[63:32];
            r_c <= r_chain[95:64];
            r_d <= r_chain[127:96];
        end else if (i_cmd.round) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + n_rot;
        end
    end

    assign o_status.pos      = r_bytes[5:0];
    assign o_mac_first_half  = r_chain[63:0];
    assign o_mac_second_half = r_chain[127:64];

endmodule
`default_nettype wire

// ===== rtl/hmd5_ctrl.sv =====
// ----------------------------------------------------------------------------
// hmd5_ctrl
// Controller: sequences key, message, padding, length and compression steps.
// ----------------------------------------------------------------------------
`default_nettype none
module hmd5_ctrl
    import hmd5_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire logic  i_has_byte,
    input  wire logic  i_is_last,
    input  wire t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_item_load,
    output logic       o_mac_valid
);

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    logic [5:0] r_cnt, n_cnt;
    logic [5:0] r_rnd, n_rnd;
    logic       r_phase, n_phase;
    logic       r_outer, n_outer;
    logic       r_has, r_last;
    t_state     n_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_cnt   <= '0;
            r_rnd   <= '0;
            r_phase <= 1'b0;
            r_outer <= 1'b0;
            r_has   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_rnd   <= n_rnd;
            r_phase <= n_phase;
            r_outer <= n_outer;
            if (o_item_load) begin
                r_has  <= i_has_byte;
                r_last <= i_is_last;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_cnt       = r_cnt;
        n_rnd       = r_rnd;
        n_phase     = r_phase;
        n_outer     = r_outer;
        n_after     = r_state;
        o_cmd       = '0;
        o_cmd.src   = SRC_ZERO;
        o_cmd.idx   = r_cnt;
        o_cmd.outer = r_outer;
        o_cmd.rnd   = r_rnd;
        o_item_load = 1'b0;
        o_mac_valid = 1'b0;
        o_busy      = (r_state != ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_item_load = 1'b1;
                    n_cnt = '0;
                    if (!r_phase) begin
                        o_cmd.init = 1'b1;
                        n_phase = 1'b1;
                        n_outer = 1'b0;
                        n_state = ST_KEY;
                    end else begin
                        n_state = ST_MSG;
                    end
                end
            end
            ST_KEY: begin
                o_cmd.absorb = 1'b1;
                o_cmd.src    = SRC_KEY;
                n_cnt        = r_cnt + 6'd1;
                n_after      = (r_cnt == 6'd63) ? (r_outer ? ST_DIG : ST_MSG) : ST_KEY;
            end
            ST_MSG: begin
                n_cnt = '0;
                if (r_has) begin
                    o_cmd.absorb = 1'b1;
                    o_cmd.src    = SRC_DATA;
                end
                n_after = r_last ? ST_PAD80 : ST_IDLE;
            end
            ST_PAD80: begin
                o_cmd.absorb = 1'b1;
                o_cmd.snap   = 1'b1;
                o_cmd.src    = SRC_PAD80;
                n_after      = ST_PADZ;
            end
            ST_PADZ: begin
                n_cnt = '0;
                if (i_status.pos == LenPos) begin
                    n_after = ST_LEN;
                end else begin
                    o_cmd.absorb = 1'b1;
                    o_cmd.src    = SRC_ZERO;
                    n_after      = ST_PADZ;
                end
            end
            ST_LEN: begin
                o_cmd.absorb = 1'b1;
                o_cmd.src    = SRC_LEN;
                n_cnt        = r_cnt + 6'd1;
                n_after      = (r_cnt == 6'd7) ? ST_POST : ST_LEN;
            end
            ST_POST: begin
                n_cnt = '0;
                if (!r_outer) begin
                    o_cmd.save_inner = 1'b1;
                    o_cmd.init       = 1'b1;
                    n_outer          = 1'b1;
                    n_state          = ST_KEY;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIG: begin
                o_cmd.absorb = 1'b1;
                o_cmd.src    = SRC_DIG;
                n_cnt        = r_cnt + 6'd1;
                n_after      = (r_cnt == 6'd15) ? ST_PAD80 : ST_DIG;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_rnd       = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = r_ret;
            end
            ST_DONE: begin
                o_mac_valid = 1'b1;
                n_phase     = 1'b0;
                n_outer     = 1'b0;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A byte that fills the block diverts through a compression first.
        if (r_state == ST_KEY || r_state == ST_MSG || r_state == ST_PAD80 ||
            r_state == ST_PADZ || r_state == ST_LEN || r_state == ST_DIG) begin
            if (o_cmd.absorb && i_status.pos == LastPos) begin
                o_cmd.load_work = 1'b1;
                n_ret   = n_after;
                n_rnd   = '0;
                n_state = ST_ROUND;
            end else begin
                n_state = n_after;
            end
        end
    end

    a_fin_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> ($past(r_state) == ST_ROUND && $past(r_rnd) == 6'd63))
        else $error("finalisation without a full set of rounds");
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mac_valid |=> (r_state == ST_IDLE && !r_phase))
        else $error("engine did not return to idle after the MAC");
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.absorb, o_cmd.round, o_cmd.fin}) <= 1)
        else $error("conflicting datapath commands");
    a_done_outer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> r_outer)
        else $error("MAC given before the outer hash");

endmodule
`default_nettype wire

// ===== rtl/hmac_md5_engine_top.sv =====
// ----------------------------------------------------------------------------
// hmac_md5_engine_top
// HMAC-MD5 engine with a key of up to 64 bytes and a byte-wide message input.
// ----------------------------------------------------------------------------
// Usage. Software writes the eight 64-bit key registers through the
// configuration channel (index 0 to 7, byte 0 in the low bits, unused bytes
// zero); o_cfg_ready is always high and writes to other indexes are dropped.
// Key writes should be made while the engine is idle.
// A message transaction is accepted when i_start is high and o_busy is low.
// It carries one message byte (if i_has_byte is set) and an end mark
// (i_is_last). The first transaction of a message first hashes the key
// XOR 0x36 block: its 64 bytes are absorbed, then compressed.
// A plain byte is then accepted and absorbed; when it completes a
// 64-byte block a compression follows, as the single MD5 round unit runs
// one round per cycle. The final transaction runs padding, the inner
// length, the outer key block, the inner digest and the outer padding
// before o_mac_valid is raised. o_mac_valid pulses for exactly one cycle
// with the MAC on o_mac_first_half and o_mac_second_half. The receiver
// cannot stall, so the result must be captured on that cycle.
// Reset clears the key registers and returns the engine to the start of a
// message; it needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module hmac_md5_engine_top
    import hmd5_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_is_last,
    output logic             o_mac_valid,
    output logic [63:0]      o_mac_first_half,
    output logic [63:0]      o_mac_second_half,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_item_load;

    // Key registers can always take a write transaction.
    assign o_cfg_ready = 1'b1;

    hmd5_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_has_byte  (i_has_byte),
        .i_is_last   (i_is_last),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_busy      (o_busy),
        .o_item_load (w_item_load),
        .o_mac_valid (o_mac_valid)
    );

    hmd5_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid & o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_item_load       (w_item_load),
        .i_data_byte       (i_data_byte),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_mac_first_half  (o_mac_first_half),
        .o_mac_second_half (o_mac_second_half)
    );

endmodule
`default_nettype wire
